// ----- rtl/brick_signed_distance_assert.svh -----
// Assertion macros used by the brick distance top level.
`ifndef BRICK_SIGNED_DISTANCE_ASSERT_SVH
`define BRICK_SIGNED_DISTANCE_ASSERT_SVH

// Condition that must hold at every clock edge out of reset.
`define BSD_ASSERT_ALWAYS(name, cond, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Condition that must hold in the cycle after the trigger.
`define BSD_ASSERT_NEXT(name, trig, cond, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) else $error(msg);

`endif

// ----- rtl/bsd_pkg.sv -----
// Shared types, constants and geometry tables for the brick distance pipeline.
package bsd_pkg;

  localparam int PT_W      = 21;
  localparam int CNT_W     = 7;
  localparam int LAY_W     = 2;
  localparam int WIDE_W    = 24;
  localparam int RAD_W     = 44;
  localparam int ROOT_W    = RAD_W / 2;
  localparam int REM_W     = ROOT_W + 2;
  localparam int MAX_STUDS = 100;

  localparam int N_FRONT = 4;
  localparam int N_SQ    = ROOT_W / 2;
  localparam int N_BACK  = 4;
  localparam int N_STAGE = N_FRONT + N_SQ + N_BACK;

  // lengths in 1/256 mm
  localparam int OUTER_TRIM   = 51;    // 1024*s - 51 is the outer box half width minus the edge radius
  localparam int CAV_TRIM     = 333;   // 1024*s - 333 is the cavity half width
  localparam int ROUND_FX     = 26;
  localparam int CAV_Y_NEG    = 154;   // cavity centre sits at y = -154
  localparam int STUD_R_FX    = 614;
  localparam int STUD_HALF_FX = 230;
  localparam int TUBE_R_FX    = 833;
  localparam int HALF_PITCH   = 1024;
  localparam int PITCH_SH     = 11;
  localparam int OUT_MAX      = 1048575;
  localparam int OUT_MIN      = -1048576;

  typedef logic signed [PT_W-1:0]   pt_t;
  typedef logic signed [WIDE_W-1:0] wide_t;
  typedef logic [RAD_W-1:0]         sq_t;
  typedef logic [ROOT_W-1:0]        root_t;
  typedef logic [REM_W-1:0]         rem_t;

  typedef enum logic [1:0] {
    REG_STUDS_ACROSS = 2'd0,
    REG_STUDS_DEEP   = 2'd1,
    REG_PLATE_LAYERS = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic [CNT_W-1:0] sx;
    logic [CNT_W-1:0] sz;
    logic [LAY_W-1:0] h;
  } cfg_t;

  // terms that bypass the square roots
  typedef struct packed {
    wide_t in_o;   // inside term of the outer box, minus edge radius
    wide_t in_i;   // inside term of the cavity box
    wide_t sv;     // stud vertical slab distance
    wide_t tv;     // tube vertical slab distance
  } side_t;

  typedef struct packed {
    sq_t   sum_o;
    sq_t   sum_i;
    sq_t   sum_s;
    sq_t   sum_t;
    side_t side;
  } front_t;

  function automatic wide_t absw(wide_t a);
    return (a < 0) ? -a : a;
  endfunction

  function automatic wide_t maxw(wide_t a, wide_t b);
    return (a > b) ? a : b;
  endfunction

  function automatic wide_t minw(wide_t a, wide_t b);
    return (a < b) ? a : b;
  endfunction

  function automatic logic [CNT_W-1:0] clamp_count(logic [CNT_W-1:0] v);
    logic [CNT_W-1:0] r;
    if (v == '0) r = CNT_W'(1);
    else if (v > CNT_W'(MAX_STUDS)) r = CNT_W'(MAX_STUDS);
    else r = v;
    return r;
  endfunction

  function automatic wide_t body_half_y(logic [LAY_W-1:0] h);
    wide_t r;
    case (h)
      2'd2:    r = wide_t'(794);
      2'd3:    r = wide_t'(1203);
      default: r = wide_t'(384);
    endcase
    return r;
  endfunction

  function automatic wide_t cav_half(logic [LAY_W-1:0] h);
    wide_t r;
    case (h)
      2'd2:    r = wide_t'(666);
      2'd3:    r = wide_t'(1075);
      default: r = wide_t'(256);
    endcase
    return r;
  endfunction

  function automatic wide_t stud_y(logic [LAY_W-1:0] h);
    wide_t r;
    case (h)
      2'd2:    r = wide_t'(1050);
      2'd3:    r = wide_t'(1459);
      default: r = wide_t'(640);
    endcase
    return r;
  endfunction

endpackage

// ----- rtl/brick_signed_distance.sv -----
// Top level of the brick signed distance pipeline.
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+---------------------------------------
//  in_     | in  | in_tvalid/tready   | in_tdata: point_x, point_y, point_z
//  out_    | out | out_tvalid/tready  | out_tdata: signed_distance
//  cfg_    | in  | cfg_valid/ready    | cfg_index, cfg_data (ready always high)
//
//  One item per cycle while out_tready is high; stages: 4 front stages (offsets,
//  grid snap, squares, sums), 11 square root stages at two root bits each,
//  4 back stages ending in the output register.
//  Reset (synchronous, rst_n low) empties the pipeline and sets one stud
//  across, one stud deep, one plate layer.
//  Every stage has its own valid bit; a stalled output only holds stages that
//  are full up to it, so empty slots keep filling and in_tready stays high
//  while any bubble remains.
module brick_signed_distance import bsd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,    // [20:0] point_x, [41:21] point_y, [62:42] point_z
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,   // [20:0] signed_distance
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [6:0]  cfg_data
);

  `include "brick_signed_distance_assert.svh"

  cfg_t cfg_r, cfg_nxt;
  logic [N_STAGE-1:0] stage_v_r, stage_v_nxt;
  logic [N_STAGE:0]   en;

  front_t front_res;
  side_t  side_r [N_SQ];
  root_t  q_o, q_i, q_s, q_t;
  rem_t   r_o, r_i, r_s, r_t;
  pt_t    sdist;

  // config: stored already clamped to the meaningful range
  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_idx_t'(cfg_index))
        REG_STUDS_ACROSS: cfg_nxt.sx = clamp_count(cfg_data);
        REG_STUDS_DEEP:   cfg_nxt.sz = clamp_count(cfg_data);
        REG_PLATE_LAYERS: cfg_nxt.h  = (cfg_data[1:0] == '0) ? LAY_W'(1) : cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // stall chain: a stage advances if it is empty or the next one advances
  assign en[N_STAGE] = out_tready;
  for (genvar k = 0; k < N_STAGE; k++) begin : g_en
    assign en[k] = ~stage_v_r[k] | en[k+1];
  end

  always_comb begin
    stage_v_nxt = stage_v_r;
    if (en[0]) stage_v_nxt[0] = in_tvalid;
    for (int k = 1; k < N_STAGE; k++) begin
      if (en[k]) stage_v_nxt[k] = stage_v_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r       <= '{sx: CNT_W'(1), sz: CNT_W'(1), h: LAY_W'(1)};
      stage_v_r   <= '0;
    end else begin
      cfg_r       <= cfg_nxt;
      stage_v_r   <= stage_v_nxt;
    end
  end

  assign in_tready = en[0];

  bsd_front u_front (
    .clk (clk),
    .en  (en[N_FRONT-1:0]),
    .cfg (cfg_r),
    .px  (in_tdata[20:0]),
    .py  (in_tdata[41:21]),
    .pz  (in_tdata[62:42]),
    .res (front_res)
  );

  bsd_sqrt u_sqrt_o (.clk(clk), .en(en[N_FRONT +: N_SQ]), .rad(front_res.sum_o),
                     .root(q_o), .rem(r_o));
  bsd_sqrt u_sqrt_i (.clk(clk), .en(en[N_FRONT +: N_SQ]), .rad(front_res.sum_i),
                     .root(q_i), .rem(r_i));
  bsd_sqrt u_sqrt_s (.clk(clk), .en(en[N_FRONT +: N_SQ]), .rad(front_res.sum_s),
                     .root(q_s), .rem(r_s));
  bsd_sqrt u_sqrt_t (.clk(clk), .en(en[N_FRONT +: N_SQ]), .rad(front_res.sum_t),
                     .root(q_t), .rem(r_t));

  // bypass terms ride alongside the root stages
  always_ff @(posedge clk) begin
    if (en[N_FRONT]) side_r[0] <= front_res.side;
  end
  for (genvar k = 1; k < N_SQ; k++) begin : g_side
    always_ff @(posedge clk) begin
      if (en[N_FRONT+k]) side_r[k] <= side_r[k-1];
    end
  end

  bsd_back u_back (
    .clk   (clk),
    .en    (en[N_FRONT+N_SQ +: N_BACK]),
    .cfg   (cfg_r),
    .q_o   (q_o), .r_o (r_o),
    .q_i   (q_i), .r_i (r_i),
    .q_s   (q_s), .r_s (r_s),
    .q_t   (q_t), .r_t (r_t),
    .side  (side_r[N_SQ-1]),
    .sdist (sdist)
  );

  assign out_tvalid = stage_v_r[N_STAGE-1];
  assign out_tdata  = {3'b000, sdist};

  `BSD_ASSERT_ALWAYS(a_ready_bubble, in_tready == ((~&stage_v_r) || out_tready),
                     "in_tready disagrees with pipeline occupancy")
  `BSD_ASSERT_NEXT(a_accept_fills, in_tvalid && in_tready, stage_v_r[0],
                   "accepted item not captured in first stage")
  `BSD_ASSERT_ALWAYS(a_cfg_range, (cfg_r.sx != '0) && (cfg_r.sx <= CNT_W'(MAX_STUDS)) &&
                     (cfg_r.sz != '0) && (cfg_r.sz <= CNT_W'(MAX_STUDS)) && (cfg_r.h != '0),
                     "config register outside clamped range")

endmodule

// ----- rtl/bsd_front.sv -----
// Front stages: box offsets, grid snapping, squares and radicand sums.
module bsd_front import bsd_pkg::*; (
  input  logic               clk,
  input  logic [N_FRONT-1:0] en,
  input  cfg_t               cfg,
  input  pt_t                px,
  input  pt_t                py,
  input  pt_t                pz,
  output front_t             res
);

  typedef struct packed {
    wide_t do0, do1, do2, di0, di1, di2;
    wide_t tsx, tsz, ttx, ttz, sv;
  } s1_t;

  typedef struct packed {
    wide_t oo0, oo1, oo2, oi0, oi1, oi2;
    wide_t dsx, dsz, dtx, dtz;
    side_t side;
  } s2_t;

  typedef struct packed {
    sq_t qo0, qo1, qo2, qi0, qi1, qi2, qsx, qsz, qtx, qtz;
    side_t side;
  } s3_t;

  s1_t s1_r, s1_nxt;
  s2_t s2_r, s2_nxt;
  s3_t s3_r, s3_nxt;
  front_t s4_r, s4_nxt;

  function automatic wide_t grid_off(wide_t t, wide_t lim);
    wide_t idx;
    idx = t >>> PITCH_SH;
    if (idx < 0) idx = '0;
    else if (idx > lim) idx = lim;
    return t - wide_t'(HALF_PITCH) - (idx <<< PITCH_SH);
  endfunction

  function automatic wide_t pos(wide_t a);
    return (a < 0) ? '0 : a;
  endfunction

  function automatic sq_t sqr(wide_t a);
    logic signed [2*WIDE_W-1:0] p;
    p = a * a;
    return p[RAD_W-1:0];
  endfunction

  // stage 1: distances past each face, shifted grid coordinates
  always_comb begin
    wide_t ax, ay, az, sx1k, sz1k, wy;
    ax   = absw(wide_t'(px));
    ay   = absw(wide_t'(py));
    az   = absw(wide_t'(pz));
    wy   = wide_t'(py);
    sx1k = wide_t'({cfg.sx, 10'b0});
    sz1k = wide_t'({cfg.sz, 10'b0});
    s1_nxt.do0 = ax - (sx1k - wide_t'(OUTER_TRIM));
    s1_nxt.do1 = ay - body_half_y(cfg.h);
    s1_nxt.do2 = az - (sz1k - wide_t'(OUTER_TRIM));
    s1_nxt.di0 = ax - (sx1k - wide_t'(CAV_TRIM));
    s1_nxt.di1 = absw(wy + wide_t'(CAV_Y_NEG)) - cav_half(cfg.h);
    s1_nxt.di2 = az - (sz1k - wide_t'(CAV_TRIM));
    s1_nxt.tsx = wide_t'(px) + sx1k;
    s1_nxt.tsz = wide_t'(pz) + sz1k;
    s1_nxt.ttx = wide_t'(px) + sx1k - wide_t'(HALF_PITCH);
    s1_nxt.ttz = wide_t'(pz) + sz1k - wide_t'(HALF_PITCH);
    s1_nxt.sv  = absw(wy - stud_y(cfg.h)) - wide_t'(STUD_HALF_FX);
  end

  // stage 2: clamp outside parts, inside terms, offsets to nearest centres
  always_comb begin
    s2_nxt.oo0 = pos(s1_r.do0);
    s2_nxt.oo1 = pos(s1_r.do1);
    s2_nxt.oo2 = pos(s1_r.do2);
    s2_nxt.oi0 = pos(s1_r.di0);
    s2_nxt.oi1 = pos(s1_r.di1);
    s2_nxt.oi2 = pos(s1_r.di2);
    s2_nxt.side.in_o = minw(maxw(s1_r.do0, maxw(s1_r.do1, s1_r.do2)), '0)
                       - wide_t'(ROUND_FX);
    s2_nxt.side.in_i = minw(maxw(s1_r.di0, maxw(s1_r.di1, s1_r.di2)), '0);
    s2_nxt.side.sv   = s1_r.sv;
    s2_nxt.side.tv   = s1_r.di1;
    s2_nxt.dsx = grid_off(s1_r.tsx, wide_t'(cfg.sx) - wide_t'(1));
    s2_nxt.dsz = grid_off(s1_r.tsz, wide_t'(cfg.sz) - wide_t'(1));
    s2_nxt.dtx = grid_off(s1_r.ttx, wide_t'(cfg.sx) - wide_t'(2));
    s2_nxt.dtz = grid_off(s1_r.ttz, wide_t'(cfg.sz) - wide_t'(2));
  end

  // stage 3: squares
  always_comb begin
    s3_nxt.qo0  = sqr(s2_r.oo0);
    s3_nxt.qo1  = sqr(s2_r.oo1);
    s3_nxt.qo2  = sqr(s2_r.oo2);
    s3_nxt.qi0  = sqr(s2_r.oi0);
    s3_nxt.qi1  = sqr(s2_r.oi1);
    s3_nxt.qi2  = sqr(s2_r.oi2);
    s3_nxt.qsx  = sqr(s2_r.dsx);
    s3_nxt.qsz  = sqr(s2_r.dsz);
    s3_nxt.qtx  = sqr(s2_r.dtx);
    s3_nxt.qtz  = sqr(s2_r.dtz);
    s3_nxt.side = s2_r.side;
  end

  // stage 4: radicands
  always_comb begin
    s4_nxt.sum_o = s3_r.qo0 + s3_r.qo1 + s3_r.qo2;
    s4_nxt.sum_i = s3_r.qi0 + s3_r.qi1 + s3_r.qi2;
    s4_nxt.sum_s = s3_r.qsx + s3_r.qsz;
    s4_nxt.sum_t = s3_r.qtx + s3_r.qtz;
    s4_nxt.side  = s3_r.side;
  end

  always_ff @(posedge clk) begin
    if (en[0]) s1_r <= s1_nxt;
    if (en[1]) s2_r <= s2_nxt;
    if (en[2]) s3_r <= s3_nxt;
    if (en[3]) s4_r <= s4_nxt;
  end

  assign res = s4_r;

endmodule

// ----- rtl/bsd_sqrt.sv -----
// Pipelined integer square root, two root bits per stage, floor plus remainder.
module bsd_sqrt import bsd_pkg::*; (
  input  logic            clk,
  input  logic [N_SQ-1:0] en,
  input  sq_t             rad,
  output root_t           root,
  output rem_t            rem
);

  typedef struct packed {
    sq_t   rad;
    rem_t  rem;
    root_t q;
  } sq_st_t;

  sq_st_t st_r [N_SQ];

  function automatic sq_st_t step2(sq_st_t s);
    sq_st_t o;
    logic [REM_W+1:0] r2, t;
    o = s;
    for (int i = 0; i < 2; i++) begin
      r2    = {o.rem, o.rad[RAD_W-1 -: 2]};
      t     = {2'b00, o.q, 2'b01};
      o.rad = o.rad << 2;
      if (r2 >= t) begin
        r2  = r2 - t;
        o.q = {o.q[ROOT_W-2:0], 1'b1};
      end else begin
        o.q = {o.q[ROOT_W-2:0], 1'b0};
      end
      o.rem = r2[REM_W-1:0];
    end
    return o;
  endfunction

  sq_st_t first_in;
  assign first_in = '{rad: rad, rem: '0, q: '0};

  always_ff @(posedge clk) begin
    if (en[0]) st_r[0] <= step2(first_in);
  end

  for (genvar k = 1; k < N_SQ; k++) begin : g_stage
    always_ff @(posedge clk) begin
      if (en[k]) st_r[k] <= step2(st_r[k-1]);
    end
  end

  assign root = st_r[N_SQ-1].q;
  assign rem  = st_r[N_SQ-1].rem;

endmodule

// ----- rtl/bsd_back.sv -----
// Back stages: root rounding, part distances, union and saturation.
module bsd_back import bsd_pkg::*; (
  input  logic              clk,
  input  logic [N_BACK-1:0] en,
  input  cfg_t              cfg,
  input  root_t             q_o,
  input  rem_t              r_o,
  input  root_t             q_i,
  input  rem_t              r_i,
  input  root_t             q_s,
  input  rem_t              r_s,
  input  root_t             q_t,
  input  rem_t              r_t,
  input  side_t             side,
  output pt_t               sdist
);

  typedef struct packed {
    wide_t ro, ri, rs, rt;
    side_t side;
  } b1_t;

  typedef struct packed {
    wide_t outer, inner, stud, tube;
  } b2_t;

  typedef struct packed {
    wide_t body, parts;
  } b3_t;

  b1_t b1_r, b1_nxt;
  b2_t b2_r, b2_nxt;
  b3_t b3_r, b3_nxt;
  pt_t dist_r, dist_nxt;
  logic tube_on;

  // nearest integer: bump when remainder exceeds the floor root
  function automatic wide_t rnd(root_t q, rem_t r);
    return wide_t'(q) + ((r > rem_t'(q)) ? wide_t'(1) : wide_t'(0));
  endfunction

  assign tube_on = (cfg.sx > CNT_W'(1)) && (cfg.sz > CNT_W'(1));

  always_comb begin
    b1_nxt.ro   = rnd(q_o, r_o);
    b1_nxt.ri   = rnd(q_i, r_i);
    b1_nxt.rs   = rnd(q_s, r_s);
    b1_nxt.rt   = rnd(q_t, r_t);
    b1_nxt.side = side;
  end

  always_comb begin
    b2_nxt.outer = b1_r.ro + b1_r.side.in_o;
    b2_nxt.inner = b1_r.ri + b1_r.side.in_i;
    b2_nxt.stud  = maxw(b1_r.rs - wide_t'(STUD_R_FX), b1_r.side.sv);
    b2_nxt.tube  = maxw(maxw(b1_r.rt - wide_t'(TUBE_R_FX), wide_t'(STUD_R_FX) - b1_r.rt),
                        b1_r.side.tv);
  end

  always_comb begin
    b3_nxt.body  = maxw(b2_r.outer, -b2_r.inner);
    b3_nxt.parts = tube_on ? minw(b2_r.stud, b2_r.tube) : b2_r.stud;
  end

  always_comb begin
    wide_t m;
    m = minw(b3_r.body, b3_r.parts);
    if (m > wide_t'(OUT_MAX)) dist_nxt = pt_t'(OUT_MAX);
    else if (m < wide_t'(OUT_MIN)) dist_nxt = pt_t'(OUT_MIN);
    else dist_nxt = m[PT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (en[0]) b1_r <= b1_nxt;
    if (en[1]) b2_r <= b2_nxt;
    if (en[2]) b3_r <= b3_nxt;
    if (en[3]) dist_r <= dist_nxt;
  end

  assign sdist = dist_r;

endmodule
